@@ src/assert_macros.svh @@
// concurrent assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SRAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/srac_pkg.sv @@
package srac_pkg;

  localparam int unsigned DEFAULT_HEAP_BYTES = 64 * 1024;
  localparam int unsigned REDZONE_BYTES      = 16;

  // shadow byte codes
  localparam logic [7:0] SH_ACCESSIBLE      = 8'h00;
  localparam logic [7:0] SH_KMALLOC_REDZONE = 8'hFC;
  localparam logic [7:0] SH_FREED           = 8'hFB;
  localparam logic [7:0] SH_FREE_PAGE       = 8'hFF;
  localparam logic [7:0] SH_SLAB_REDZONE    = 8'hF2;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CHECK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE         = 2'd0,
    STATUS_ALLOC_FAIL   = 2'd1,
    STATUS_FREE_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    VERDICT_CLEAN = 2'd0,
    VERDICT_UAF   = 2'd1,
    VERDICT_OOB   = 2'd2
  } verdict_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic paint;
    logic bump_add;
    logic rd;
    logic rd_next;
    logic walk_wr;
    logic load_res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic alloc_fail;
    logic alloc_last;
    logic free_bad;
    logic walk_go;
    logic chk_out;
  } sts_t;

endpackage

@@ src/srac_if.sv @@
interface srac_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] alloc_size;
  logic [16:0] address;

  modport source (output valid, output kind, output alloc_size, output address, input ready);
  modport sink   (input valid, input kind, input alloc_size, input address, output ready);
endinterface

interface srac_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] object_offset;
  logic [1:0]  verdict;

  modport source (output valid, output status, output object_offset, output verdict,
                  input ready);
  modport sink   (input valid, input status, input object_offset, input verdict,
                  output ready);
endinterface

@@ src/shadow_redzone_allocator_checker_unit.sv @@
// channel  dir  handshake     payload
// in_i     in   valid/ready   kind, alloc_size, address
// out_o    out  valid/ready   status, object_offset, verdict
//
// alloc: paints 4 + ceil(size/8) shadow entries, one entry per cycle
// free: walks the run of accessible entries, marking each freed; check: one shadow read if inside the heap
// a failed alloc or an ignored free goes straight to its result
// after reset the shadow memory is cleared, one entry a cycle, all
// ceil(HEAP_BYTES/8) entries (8192 at the default), before the first item is taken
// the result sits in an output register; a stalled result holds off only the
// completion of the next item, not its acceptance
module shadow_redzone_allocator_checker_unit import srac_pkg::*; #(
  parameter int unsigned HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srac_req_if.sink   in_i,
  srac_rsp_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  srac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_kind_i   (in_i.kind),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srac_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (in_i.kind),
    .alloc_size_i    (in_i.alloc_size),
    .address_i       (in_i.address),
    .status_o        (out_o.status),
    .object_offset_o (out_o.object_offset),
    .verdict_o       (out_o.verdict)
  );

endmodule

@@ src/srac_ctrl.sv @@
module srac_ctrl import srac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_WALK,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (kind_e'(in_kind_i))
            KIND_ALLOC: state_d = ST_ALLOC;
            KIND_FREE:  state_d = ST_FREE;
            KIND_CHECK: state_d = ST_CHECK;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (sts_i.alloc_fail) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.paint = 1'b1;
          if (sts_i.alloc_last) begin
            cmd_o.bump_add = 1'b1;
            state_d        = ST_DONE;
          end
        end
      end
      ST_FREE: begin
        if (sts_i.free_bad) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        // poison this entry and fetch the next one in the same cycle
        if (sts_i.walk_go) begin
          cmd_o.walk_wr = 1'b1;
          cmd_o.rd      = 1'b1;
          cmd_o.rd_next = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (!sts_i.chk_out) cmd_o.rd = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_res = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/srac_dp.sv @@
module srac_dp import srac_pkg::*; #(
  parameter int unsigned HEAP_BYTES = DEFAULT_HEAP_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] alloc_size_i,
  input  logic [16:0] address_i,
  output logic [1:0]  status_o,
  output logic [15:0] object_offset_o,
  output logic [1:0]  verdict_o
);

  localparam int unsigned Depth = (HEAP_BYTES + 7) / 8;
  localparam int unsigned IW    = $clog2(Depth);
  localparam int unsigned IW1   = $clog2(Depth + 1);
  localparam int unsigned BW    = $clog2(HEAP_BYTES + 1);

  logic [7:0]     mem_q [Depth];
  logic [7:0]     rdata_q;

  logic [BW-1:0]  bump_q;
  logic [IW1-1:0] idx_q;
  logic [13:0]    cnt_q;

  logic [1:0]     kind_q;
  logic [13:0]    obj_q;
  logic [15:0]    off_q;
  logic           fail_q;
  logic           outside_q;
  logic           low_q;

  logic [1:0]     status_q;
  logic [15:0]    offset_q;
  logic [1:0]     verdict_q;

  logic [16:0]    aligned;
  logic [31:0]    need;
  logic [7:0]     paint_val;
  logic           mem_we;
  logic [7:0]     mem_wdata;
  logic [IW-1:0]  mem_raddr;
  logic [IW1-1:0] idx_inc;

  logic [1:0]     status_d;
  logic [15:0]    offset_d;
  logic [1:0]     verdict_d;

  assign aligned = ({1'b0, alloc_size_i} + 17'd7) & ~17'd7;
  assign need    = 32'(bump_q) + 32'(2 * REDZONE_BYTES) + 32'(aligned);
  assign idx_inc = idx_q + IW1'(1);

  // left redzone, object body, right redzone
  assign paint_val = (cnt_q < 14'd2 || cnt_q >= obj_q + 14'd2) ? SH_KMALLOC_REDZONE
                                                               : SH_ACCESSIBLE;

  assign mem_we    = cmd_i.clear || cmd_i.paint || cmd_i.walk_wr;
  assign mem_wdata = cmd_i.clear ? SH_ACCESSIBLE : (cmd_i.paint ? paint_val : SH_FREED);
  assign mem_raddr = cmd_i.rd_next ? IW'(idx_inc) : idx_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q[IW-1:0]] <= mem_wdata;
    if (cmd_i.rd) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.capture) begin
        cnt_q <= '0;
        idx_q <= (kind_e'(kind_i) == KIND_ALLOC) ? IW1'(bump_q >> 3) : IW1'(address_i >> 3);
      end else begin
        if (cmd_i.clear || cmd_i.paint || cmd_i.walk_wr) idx_q <= idx_inc;
        if (cmd_i.paint) cnt_q <= cnt_q + 14'd1;
      end
      if (cmd_i.bump_add) begin
        bump_q <= BW'(32'(bump_q) + 32'({obj_q, 3'b000}) + 32'(2 * REDZONE_BYTES));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      obj_q     <= aligned[16:3];
      fail_q    <= need > 32'(HEAP_BYTES);
      off_q     <= 16'(32'(bump_q) + 32'(REDZONE_BYTES));
      outside_q <= 32'(address_i) >= 32'(HEAP_BYTES);
      low_q     <= address_i < 17'(REDZONE_BYTES);
    end
    if (cmd_i.load_res) begin
      status_q  <= status_d;
      offset_q  <= offset_d;
      verdict_q <= verdict_d;
    end
  end

  always_comb begin
    status_d  = STATUS_DONE;
    offset_d  = '0;
    verdict_d = VERDICT_CLEAN;
    case (kind_e'(kind_q))
      KIND_ALLOC: begin
        if (fail_q) status_d = STATUS_ALLOC_FAIL;
        else        offset_d = off_q;
      end
      KIND_FREE: begin
        if (outside_q || low_q) status_d = STATUS_FREE_IGNORED;
      end
      KIND_CHECK: begin
        if (!outside_q) begin
          if (rdata_q == SH_FREED || rdata_q == SH_FREE_PAGE) begin
            verdict_d = VERDICT_UAF;
          end else if (rdata_q == SH_KMALLOC_REDZONE || rdata_q == SH_SLAB_REDZONE) begin
            verdict_d = VERDICT_OOB;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.clear_last = (idx_q == IW1'(Depth - 1));
  assign sts_o.alloc_fail = fail_q;
  assign sts_o.alloc_last = (cnt_q == obj_q + 14'd3);
  assign sts_o.free_bad   = outside_q || low_q;
  assign sts_o.walk_go    = (rdata_q == SH_ACCESSIBLE) && (idx_q < IW1'(Depth));
  assign sts_o.chk_out    = outside_q;

  assign status_o        = status_q;
  assign object_offset_o = offset_q;
  assign verdict_o       = verdict_q;

endmodule

@@ src/srac_checker.sv @@
`include "assert_macros.svh"

module srac_checker import srac_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [15:0] out_offset_i,
  input logic [1:0]  out_verdict_i
);

  // a stalled result keeps its payload
  `SRAC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i) && $stable(out_offset_i) && $stable(out_verdict_i))

  // one item at a time: busy right after an accept
  `SRAC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // a verdict only comes with a plain done status and no offset
  `SRAC_ASSERT_IMP(a_verdict_alone, out_valid_i && out_verdict_i != VERDICT_CLEAN, out_status_i == STATUS_DONE && out_offset_i == 16'd0)

  // failed or ignored items carry no offset and no verdict
  `SRAC_ASSERT_IMP(a_error_empty, out_valid_i && out_status_i != STATUS_DONE, out_offset_i == 16'd0 && out_verdict_i == VERDICT_CLEAN)

endmodule

bind shadow_redzone_allocator_checker_unit srac_checker u_srac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_offset_i  (out_o.object_offset),
  .out_verdict_i (out_o.verdict)
);

@@ tb/shadow_redzone_allocator_checker_unit_tb.sv @@
`timescale 1ns / 100ps

module shadow_redzone_allocator_checker_unit_tb import srac_pkg::*;;

  localparam int unsigned HEAP_SPAN    = DEFAULT_HEAP_BYTES;
  localparam int unsigned SHADOW_DEPTH = (HEAP_SPAN + 7) / 8;
  localparam int unsigned RANDOM_ITEMS = 1580;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  // clearing pass and the longest free walk each cover about 8k shadow entries with no item moving
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  // kind three does nothing
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct {
    status_e     status;
    logic [15:0] object_offset;
    verdict_e    verdict;
  } rsp_t;

  class redzone_scoreboard;
    logic [7:0]  shadow_q [SHADOW_DEPTH];
    int unsigned bump_q;
    rsp_t        pending_q [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned allocs_done, allocs_failed, frees_done, frees_ignored;
    int unsigned checks_clean, checks_uaf, checks_oob;

    function new();
      foreach (shadow_q[i]) shadow_q[i] = SH_ACCESSIBLE;
      bump_q = 0;
    endfunction

    function rsp_t predict(logic [1:0] kind, logic [15:0] size, logic [16:0] addr);
      rsp_t        r;
      int unsigned aligned, span, base, idx;
      logic [7:0]  sv;
      r.status        = STATUS_DONE;
      r.object_offset = '0;
      r.verdict       = VERDICT_CLEAN;
      case (kind)
        KIND_ALLOC: begin
          aligned = (int'(size) + 7) & ~32'd7;
          span    = 2 * REDZONE_BYTES + aligned;
          if (bump_q + span > HEAP_SPAN) begin
            r.status = STATUS_ALLOC_FAIL;
            allocs_failed++;
          end else begin
            base = bump_q / 8;
            for (int unsigned i = 0; i < span / 8; i++) begin
              idx = base + i;
              if (idx < SHADOW_DEPTH)
                shadow_q[idx] = (i < 2 || i >= 2 + aligned / 8) ? SH_KMALLOC_REDZONE
                                                                 : SH_ACCESSIBLE;
            end
            r.object_offset = 16'(bump_q + REDZONE_BYTES);
            bump_q += span;
            allocs_done++;
          end
        end
        KIND_FREE: begin
          if (addr >= HEAP_SPAN || addr < REDZONE_BYTES) begin
            r.status = STATUS_FREE_IGNORED;
            frees_ignored++;
          end else begin
            idx = (int'(addr) - REDZONE_BYTES) / 8 + 2;
            while (idx < SHADOW_DEPTH && shadow_q[idx] == SH_ACCESSIBLE) begin
              shadow_q[idx] = SH_FREED;
              idx++;
            end
            frees_done++;
          end
        end
        KIND_CHECK: begin
          if (addr < HEAP_SPAN) begin
            sv = shadow_q[addr / 8];
            if (sv == SH_FREED || sv == SH_FREE_PAGE)
              r.verdict = VERDICT_UAF;
            else if (sv == SH_KMALLOC_REDZONE || sv == SH_SLAB_REDZONE)
              r.verdict = VERDICT_OOB;
          end
          case (r.verdict)
            VERDICT_UAF: checks_uaf++;
            VERDICT_OOB: checks_oob++;
            default:     checks_clean++;
          endcase
        end
        default: ;
      endcase
      return r;
    endfunction

    function rsp_t note_request(logic [1:0] kind, logic [15:0] size, logic [16:0] addr);
      rsp_t r;
      r = predict(kind, size, addr);
      pending_q.push_back(r);
      return r;
    endfunction

    task report(string msg);
      $display("error at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_response(logic [1:0] status, logic [15:0] offset, logic [1:0] verdict);
      rsp_t exp;
      results_seen++;
      if (pending_q.size() == 0) begin
        report("result arrived with nothing pending");
      end else begin
        exp = pending_q.pop_front();
        if (status !== exp.status)
          report($sformatf("status %0d, expected %0d", status, exp.status));
        if (offset !== exp.object_offset)
          report($sformatf("object_offset %0h, expected %0h", offset, exp.object_offset));
        if (verdict !== exp.verdict)
          report($sformatf("verdict %0d, expected %0d", verdict, exp.verdict));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  srac_req_if in_if ();
  srac_rsp_if out_if ();

  shadow_redzone_allocator_checker_unit #(
    .HEAP_BYTES(HEAP_SPAN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  redzone_scoreboard sb = new();

  bit          idle_en  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;

  // live objects, kept after free so that double frees happen
  int unsigned obj_off_q [$];
  int unsigned obj_len_q [$];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_item(logic [1:0] kind, logic [15:0] size, logic [16:0] addr);
    rsp_t exp;
    while (idle_en && hold_cnt == 0 && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.alloc_size <= size;
    in_if.address    <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    exp = sb.note_request(kind, size, addr);
    if (kind == KIND_ALLOC && exp.status == STATUS_DONE) begin
      obj_off_q.push_back(exp.object_offset);
      obj_len_q.push_back((int'(size) + 7) & ~32'd7);
    end
  endtask

  // receiver side: check results, drive ready
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_response(out_if.status, out_if.object_offset, out_if.verdict);
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_en && $urandom_range(99) < 10);
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sel, pick, off, len;
    logic [1:0]  kind;
    logic [15:0] size;
    logic [16:0] addr;

    rst_ni           = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_NOP;
    in_if.alloc_size <= '0;
    in_if.address    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty heap, outside addresses, tiny and oversized objects, frees and rechecks
    send_item(KIND_CHECK, 16'h0000, 17'd0);
    send_item(KIND_CHECK, 16'h0000, 17'd65536);
    send_item(KIND_CHECK, 16'hFFFF, 17'h1FFFF);
    send_item(KIND_FREE,  16'h0000, 17'd5);
    send_item(KIND_FREE,  16'h0000, 17'd65536);
    send_item(KIND_FREE,  16'hFFFF, 17'h1FFFF);
    send_item(KIND_NOP,   16'hFFFF, 17'h1FFFF);
    send_item(KIND_ALLOC, 16'd0,    17'd0);
    send_item(KIND_ALLOC, 16'd1,    17'h1FFFF);
    send_item(KIND_ALLOC, 16'd8,    17'd0);
    send_item(KIND_ALLOC, 16'hFFFF, 17'd0);
    send_item(KIND_CHECK, 16'h0000, 17'd16);
    send_item(KIND_CHECK, 16'h0000, 17'd40);
    send_item(KIND_CHECK, 16'h0000, 17'd48);
    send_item(KIND_CHECK, 16'h0000, 17'd56);
    send_item(KIND_FREE,  16'h0000, 17'd48);
    send_item(KIND_CHECK, 16'h0000, 17'd48);
    send_item(KIND_FREE,  16'h0000, 17'd48);
    send_item(KIND_CHECK, 16'h0000, 17'd48);
    send_item(KIND_FREE,  16'h0000, 17'd16);
    // free inside untouched space runs to the end of the shadow
    send_item(KIND_FREE,  16'h0000, 17'd65520);
    send_item(KIND_CHECK, 16'h0000, 17'd65528);
    send_item(KIND_CHECK, 16'h0000, 17'd65535);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = !(n >= 500 && n < 900);
      if (n == 200)
        hold_req = 1'b1;
      size = 16'($urandom_range(0, 65535));
      addr = 17'($urandom_range(0, 131071));
      sel  = $urandom_range(99);
      if (obj_off_q.size() != 0) begin
        pick = $urandom_range(0, obj_off_q.size() - 1);
        off  = obj_off_q[pick];
        len  = obj_len_q[pick];
      end
      if (sel < 35) begin
        kind = KIND_ALLOC;
        sel  = $urandom_range(99);
        if (sel < 60)
          size = 16'($urandom_range(0, 64));
        else if (sel < 85)
          size = 16'($urandom_range(65, 1024));
        else if (sel < 90)
          size = 16'd0;
      end else if (sel < 55) begin
        kind = KIND_FREE;
        sel  = $urandom_range(99);
        if (sel < 70 && obj_off_q.size() != 0)
          addr = 17'(off);
        else if (sel < 80 && obj_off_q.size() != 0)
          addr = 17'(off + 8 * $urandom_range(0, len / 8));
        else if (sel < 90)
          addr = 17'($urandom_range(0, HEAP_SPAN - 1));
        else if (sel < 95)
          addr = 17'($urandom_range(0, REDZONE_BYTES - 1));
      end else if (sel < 95) begin
        kind = KIND_CHECK;
        sel  = $urandom_range(99);
        if (sel < 70 && obj_off_q.size() != 0)
          addr = 17'(off - REDZONE_BYTES + $urandom_range(0, len + 31));
        else if (sel < 90)
          addr = 17'($urandom_range(0, HEAP_SPAN - 1));
      end else begin
        kind = KIND_NOP;
      end
      send_item(kind, size, addr);
    end
    in_if.valid <= 1'b0;
    idle_en = 1'b1;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("allocations: %0d placed, %0d refused; frees: %0d applied, %0d ignored",
             sb.allocs_done, sb.allocs_failed, sb.frees_done, sb.frees_ignored);
    $display("accesses: %0d clean, %0d use-after-free, %0d out-of-bounds; %0d results",
             sb.checks_clean, sb.checks_uaf, sb.checks_oob, sb.results_seen);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
